FILE: design/demand_paging_translator_macros.svh
// Assertion macros used by the checker file dpt_checker.sv.
`ifndef DEMAND_PAGING_TRANSLATOR_MACROS_SVH
`define DEMAND_PAGING_TRANSLATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/dpt_pkg.sv
`default_nettype none

package dpt_pkg;

	// Fixed field widths
	localparam int unsigned OFFSET_W   = 12;
	localparam int unsigned VADDR_W    = 32;
	localparam int unsigned PID_IN_W   = 2;
	localparam int unsigned FRAME_W    = 12;
	localparam int unsigned PADDR_W    = 24;
	localparam int unsigned OUTCOME_W  = 3;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned MAPPED_W   = 11;
	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned CFG_IDX_W  = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PHYS_PAGES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYS_PAGES  = 2'd1;

	// Register reset values
	localparam logic [CFG_DATA_W-1:0] PHYS_PAGES_RST = 13'd4096;
	localparam logic [CFG_DATA_W-1:0] SYS_PAGES_RST  = 13'd0;

	// Translation outcome codes
	typedef enum logic [OUTCOME_W-1:0] {
		OUT_HIT       = 3'd0,
		OUT_POOL      = 3'd1,
		OUT_STEAL     = 3'd2,
		OUT_RANGE     = 3'd3,
		OUT_NO_VICTIM = 3'd4
	} outcome_t;

endpackage

`default_nettype wire

FILE: design/demand_paging_translator.sv
// Demand-paging address translator.
// Input channel (in_valid/in_ready): process_id and a 32-bit virtual_address.
// Output channel (out_valid/out_ready): frame_number, physical_address,
// outcome and the process's hit, pool, fault and mapped-page counts.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets
// the physical page count, index 1 the system page count; always ready.
// One item is in work at a time; in_ready is high only while idle.
// An out-of-range page goes from idle straight to the done state; a hit, a
// pool allocation or a fault with no victim passes lookup and check first.
// A fault that steals walks the process's page table one entry a cycle
// through the single table read port up to the lowest valid page number
// of that process, then steals it. A new item is taken only once the last
// result has been loaded into the output register and the block is idle.
// After reset a clearing pass writes every table entry invalid, one entry a
// cycle, PROCESS_COUNT * VIRTUAL_PAGES entries (4096 by default); no input is
// taken until it ends. A finished result sits in the output register; when
// the receiver stalls, the next item may be accepted and worked, and it
// waits in its final state until the output register frees up.
`default_nettype none

module demand_paging_translator #(
	parameter int unsigned PROCESS_COUNT      = 4,
	parameter int unsigned VIRTUAL_PAGES      = 1024,
	parameter int unsigned MAX_PHYSICAL_PAGES = 4096
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// config write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [dpt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [dpt_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [dpt_pkg::PID_IN_W-1:0]        process_id,
	input  wire logic [dpt_pkg::VADDR_W-1:0]         virtual_address,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [dpt_pkg::FRAME_W-1:0]              frame_number,
	output logic [dpt_pkg::PADDR_W-1:0]              physical_address,
	output logic [dpt_pkg::OUTCOME_W-1:0]            outcome,
	output logic [dpt_pkg::COUNT_W-1:0]              hits_so_far,
	output logic [dpt_pkg::COUNT_W-1:0]              pool_allocs_so_far,
	output logic [dpt_pkg::COUNT_W-1:0]              faults_so_far,
	output logic [dpt_pkg::MAPPED_W-1:0]             mapped_pages
);

	localparam int unsigned DEPTH = PROCESS_COUNT * VIRTUAL_PAGES;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned PW    = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
	localparam int unsigned VPW   = $clog2(VIRTUAL_PAGES);
	localparam int unsigned MCW   = $clog2(VIRTUAL_PAGES + 1);
	localparam int unsigned FW    = $clog2(MAX_PHYSICAL_PAGES);
	localparam int unsigned PCW0  = $clog2(MAX_PHYSICAL_PAGES + 1);
	localparam int unsigned PCW   = (PCW0 > dpt_pkg::CFG_DATA_W) ? PCW0 : dpt_pkg::CFG_DATA_W;
	localparam int unsigned VPN_W = dpt_pkg::VADDR_W - dpt_pkg::OFFSET_W;

	localparam logic [AW-1:0]  CLR_LAST  = AW'(DEPTH - 1);
	localparam logic [VPW-1:0] SCAN_LAST = VPW'(VIRTUAL_PAGES - 1);
	localparam logic [PCW-1:0] PHYS_MAX  = PCW'(MAX_PHYSICAL_PAGES);
	localparam logic [dpt_pkg::COUNT_W-1:0] SAT_MAX = '1;
	localparam logic [dpt_pkg::COUNT_W-1:0] MAPPED_SAT =
		dpt_pkg::COUNT_W'((1 << dpt_pkg::MAPPED_W) - 1);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_LOOKUP = 7'b0000100,
		ST_CHECK  = 7'b0001000,
		ST_SCAN   = 7'b0010000,
		ST_STEAL  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	// Fold the process number onto the configured process count.
	function automatic logic [PW-1:0] wrap_pid(input logic [dpt_pkg::PID_IN_W-1:0] p);
		logic [4:0] v;
		v = 5'(p);
		for (int i = 0; i < 3; i++) begin
			if (v >= 5'(PROCESS_COUNT)) begin
				v = v - 5'(PROCESS_COUNT);
			end
		end
		return PW'(v);
	endfunction

	function automatic logic [dpt_pkg::COUNT_W-1:0] sat_inc(
		input logic [dpt_pkg::COUNT_W-1:0] v
	);
		return (v == SAT_MAX) ? v : v + 1'b1;
	endfunction

	state_t state_q;

	logic [dpt_pkg::CFG_DATA_W-1:0] phys_cfg_q;
	logic [dpt_pkg::CFG_DATA_W-1:0] sys_cfg_q;

	// page table: valid bit above the frame
	logic [FW:0] table_q [DEPTH];
	logic [FW:0] rd_q;
	logic        rd_en;
	logic [AW-1:0] rd_addr;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [FW:0] wr_data;

	logic [AW-1:0] clr_idx_q;

	logic [PW-1:0]  pid_q;
	logic [AW-1:0]  base_q;
	logic [AW-1:0]  addr_q;
	logic [dpt_pkg::OFFSET_W-1:0] offset_q;
	logic [FW-1:0]  frame_q;
	dpt_pkg::outcome_t outcome_q;

	logic [PCW-1:0] phys_q;
	logic [PCW-1:0] user_q;
	logic [PCW-1:0] pool_taken_q;
	logic [PCW-1:0] phys_lim;
	logic           pool_avail;
	logic [FW-1:0]  pool_frame;

	logic [VPW-1:0] scan_idx_q;
	logic [AW-1:0]  scan_addr_s1;
	logic           scan_pend_s1;
	logic           victim_hit;

	logic [dpt_pkg::COUNT_W-1:0] hit_cnt_q    [PROCESS_COUNT];
	logic [dpt_pkg::COUNT_W-1:0] pool_cnt_q   [PROCESS_COUNT];
	logic [dpt_pkg::COUNT_W-1:0] fault_cnt_q  [PROCESS_COUNT];
	logic [MCW-1:0]              mapped_cnt_q [PROCESS_COUNT];

	logic [VPN_W-1:0] in_vpn;
	logic             in_range;
	logic             in_xfer;
	logic             out_load;
	logic [dpt_pkg::COUNT_W-1:0] frame_ext;
	logic [dpt_pkg::COUNT_W-1:0] mapped_ext;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid || out_ready);

	assign in_vpn   = virtual_address[dpt_pkg::VADDR_W-1:dpt_pkg::OFFSET_W];
	assign in_range = (21'(in_vpn) < 21'(VIRTUAL_PAGES));

	// Pool bookkeeping against the current register values
	assign phys_lim   = (PCW'(phys_cfg_q) > PHYS_MAX) ? PHYS_MAX : PCW'(phys_cfg_q);
	assign pool_avail = (pool_taken_q < user_q);
	assign pool_frame = FW'(phys_q - pool_taken_q - 1'b1);

	assign victim_hit = scan_pend_s1 && rd_q[FW];

	// Table read port
	always_comb begin
		rd_en   = (state_q == ST_LOOKUP) || (state_q == ST_SCAN);
		rd_addr = (state_q == ST_SCAN) ? base_q + AW'(scan_idx_q) : addr_q;
	end

	// Table write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = {1'b1, frame_q};
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_idx_q;
				wr_data = '0;
			end
			ST_CHECK: begin
				wr_en   = !rd_q[FW] && pool_avail;
				wr_data = {1'b1, pool_frame};
			end
			ST_SCAN: begin
				wr_en   = victim_hit;
				wr_addr = scan_addr_s1;
				wr_data = '0;
			end
			ST_STEAL: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Page table storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= table_q[rd_addr];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phys_cfg_q <= dpt_pkg::PHYS_PAGES_RST;
			sys_cfg_q  <= dpt_pkg::SYS_PAGES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dpt_pkg::CFG_PHYS_PAGES: phys_cfg_q <= cfg_data;
				dpt_pkg::CFG_SYS_PAGES:  sys_cfg_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and per-process counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_idx_q    <= '0;
			pool_taken_q <= '0;
			scan_pend_s1 <= 1'b0;
			for (int p = 0; p < PROCESS_COUNT; p++) begin
				hit_cnt_q[p]    <= '0;
				pool_cnt_q[p]   <= '0;
				fault_cnt_q[p]  <= '0;
				mapped_cnt_q[p] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= in_range ? ST_LOOKUP : ST_DONE;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (rd_q[FW]) begin
						hit_cnt_q[pid_q] <= sat_inc(hit_cnt_q[pid_q]);
						state_q <= ST_DONE;
					end else if (pool_avail) begin
						pool_taken_q       <= pool_taken_q + 1'b1;
						pool_cnt_q[pid_q]  <= sat_inc(pool_cnt_q[pid_q]);
						mapped_cnt_q[pid_q] <= mapped_cnt_q[pid_q] + 1'b1;
						state_q <= ST_DONE;
					end else begin
						fault_cnt_q[pid_q] <= sat_inc(fault_cnt_q[pid_q]);
						// no mapped page means no victim: skip the walk
						state_q <= (mapped_cnt_q[pid_q] == '0) ? ST_DONE : ST_SCAN;
						scan_pend_s1 <= 1'b0;
					end
				end
				ST_SCAN: begin
					scan_pend_s1 <= 1'b1;
					if (victim_hit) begin
						scan_pend_s1 <= 1'b0;
						state_q <= ST_STEAL;
					end
				end
				ST_STEAL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					pid_q     <= wrap_pid(process_id);
					base_q    <= AW'(wrap_pid(process_id) * VIRTUAL_PAGES);
					addr_q    <= AW'(wrap_pid(process_id) * VIRTUAL_PAGES)
						+ AW'(in_vpn[VPW-1:0]);
					offset_q  <= virtual_address[dpt_pkg::OFFSET_W-1:0];
					frame_q   <= '0;
					outcome_q <= dpt_pkg::OUT_RANGE;
				end
			end
			ST_LOOKUP: begin
				phys_q <= phys_lim;
				user_q <= (phys_lim > PCW'(sys_cfg_q)) ? phys_lim - PCW'(sys_cfg_q) : '0;
			end
			ST_CHECK: begin
				scan_idx_q <= '0;
				if (rd_q[FW]) begin
					frame_q   <= rd_q[FW-1:0];
					outcome_q <= dpt_pkg::OUT_HIT;
				end else if (pool_avail) begin
					frame_q   <= pool_frame;
					outcome_q <= dpt_pkg::OUT_POOL;
				end else begin
					frame_q   <= '0;
					outcome_q <= dpt_pkg::OUT_NO_VICTIM;
				end
			end
			ST_SCAN: begin
				// walk one entry a cycle, read data returns in the next cycle
				scan_addr_s1 <= rd_addr;
				if (scan_idx_q != SCAN_LAST) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (victim_hit) begin
					frame_q   <= rd_q[FW-1:0];
					outcome_q <= dpt_pkg::OUT_STEAL;
				end
			end
			default: ;
		endcase
	end

	assign frame_ext  = dpt_pkg::COUNT_W'(frame_q);
	assign mapped_ext = dpt_pkg::COUNT_W'(mapped_cnt_q[pid_q]);

	// Output valid: drop on transfer, raise on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			frame_number       <= frame_ext[dpt_pkg::FRAME_W-1:0];
			physical_address   <= {frame_ext[dpt_pkg::FRAME_W-1:0], offset_q};
			outcome            <= outcome_q;
			hits_so_far        <= hit_cnt_q[pid_q];
			pool_allocs_so_far <= pool_cnt_q[pid_q];
			faults_so_far      <= fault_cnt_q[pid_q];
			mapped_pages       <= (mapped_ext > MAPPED_SAT) ? '1
				: mapped_ext[dpt_pkg::MAPPED_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: design/dpt_checker.sv
`default_nettype none
`include "demand_paging_translator_macros.svh"

module dpt_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [dpt_pkg::FRAME_W-1:0]    frame_number,
	input wire logic [dpt_pkg::PADDR_W-1:0]    physical_address,
	input wire logic [dpt_pkg::OUTCOME_W-1:0]  outcome,
	input wire logic [dpt_pkg::COUNT_W-1:0]    hits_so_far,
	input wire logic [dpt_pkg::COUNT_W-1:0]    pool_allocs_so_far,
	input wire logic [dpt_pkg::COUNT_W-1:0]    faults_so_far,
	input wire logic [dpt_pkg::MAPPED_W-1:0]   mapped_pages
);

	// Physical address carries the frame in its upper bits
	`DPT_ASSERT_NOW(a_paddr_frame, out_valid, physical_address[23:12] == frame_number, "physical address does not match frame")

	// No frame when out of range or no victim
	`DPT_ASSERT_NOW(a_zero_frame, out_valid && (outcome == dpt_pkg::OUT_RANGE || outcome == dpt_pkg::OUT_NO_VICTIM), frame_number == '0, "frame not zero without a mapping")

	// Hit, pool and steal outcomes are reflected in their counters and a nonzero mapped count
	`DPT_ASSERT_NOW(a_counts, out_valid && (outcome == dpt_pkg::OUT_HIT || outcome == dpt_pkg::OUT_POOL || outcome == dpt_pkg::OUT_STEAL), mapped_pages != '0 && (outcome != dpt_pkg::OUT_HIT || hits_so_far != '0) && (outcome != dpt_pkg::OUT_POOL || pool_allocs_so_far != '0) && (outcome != dpt_pkg::OUT_STEAL || faults_so_far != '0), "counter disagrees with outcome")

	// Stalled result holds
	`DPT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(physical_address) && $stable(outcome), "stalled result changed")

endmodule

bind demand_paging_translator dpt_checker u_dpt_checker (.*);

`default_nettype wire

FILE: tb/demand_paging_translator_checker.sv
`timescale 1ns / 1ps

module demand_paging_translator_checker #(
	parameter int unsigned PROCESS_COUNT      = 4,
	parameter int unsigned VIRTUAL_PAGES      = 1024,
	parameter int unsigned MAX_PHYSICAL_PAGES = 4096
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [dpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dpt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire logic [dpt_pkg::PID_IN_W-1:0]   process_id,
	input  wire logic [dpt_pkg::VADDR_W-1:0]    virtual_address,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire logic [dpt_pkg::FRAME_W-1:0]    frame_number,
	input  wire logic [dpt_pkg::PADDR_W-1:0]    physical_address,
	input  wire logic [dpt_pkg::OUTCOME_W-1:0]  outcome,
	input  wire logic [dpt_pkg::COUNT_W-1:0]    hits_so_far,
	input  wire logic [dpt_pkg::COUNT_W-1:0]    pool_allocs_so_far,
	input  wire logic [dpt_pkg::COUNT_W-1:0]    faults_so_far,
	input  wire logic [dpt_pkg::MAPPED_W-1:0]   mapped_pages,
	output int unsigned                         failures,
	output int unsigned                         outstanding
);

	localparam int unsigned TABLE_DEPTH = PROCESS_COUNT * VIRTUAL_PAGES;

	typedef struct packed {
		logic [dpt_pkg::FRAME_W-1:0]  frame;
		logic [dpt_pkg::PADDR_W-1:0]  paddr;
		dpt_pkg::outcome_t            kind;
		logic [dpt_pkg::COUNT_W-1:0]  hits;
		logic [dpt_pkg::COUNT_W-1:0]  pool_allocs;
		logic [dpt_pkg::COUNT_W-1:0]  faults;
		logic [dpt_pkg::MAPPED_W-1:0] mapped;
	} translation_t;

	// Shadow copy of the page tables, the pool and the per-process counters
	logic [dpt_pkg::CFG_DATA_W-1:0] total_page_cfg;
	logic [dpt_pkg::CFG_DATA_W-1:0] reserved_page_cfg;
	bit                             page_valid [TABLE_DEPTH];
	logic [dpt_pkg::FRAME_W-1:0]    page_frame [TABLE_DEPTH];
	logic [dpt_pkg::CFG_DATA_W-1:0] pool_taken;
	logic [dpt_pkg::COUNT_W-1:0]    hit_count   [PROCESS_COUNT];
	logic [dpt_pkg::COUNT_W-1:0]    pool_count  [PROCESS_COUNT];
	logic [dpt_pkg::COUNT_W-1:0]    fault_count [PROCESS_COUNT];
	logic [dpt_pkg::MAPPED_W-1:0]   mapped_count [PROCESS_COUNT];

	translation_t pending_translations [$];
	int unsigned  mismatches = 0;

	assign failures = mismatches;

	function automatic logic [dpt_pkg::COUNT_W-1:0] bump(
			input logic [dpt_pkg::COUNT_W-1:0] value);
		return (value == '1) ? value : value + 1'b1;
	endfunction

	// Work out one translation and update the shadow state
	task automatic translate(input logic [dpt_pkg::PID_IN_W-1:0] pid_in,
			input logic [dpt_pkg::VADDR_W-1:0] vaddr, output translation_t res);
		int unsigned pid;
		int unsigned vpn;
		int unsigned base;
		int unsigned vp;
		int unsigned phys;
		int unsigned free_pool_size;
		logic [dpt_pkg::FRAME_W-1:0] frame;
		pid = pid_in % PROCESS_COUNT;
		vpn = vaddr[dpt_pkg::VADDR_W-1:dpt_pkg::OFFSET_W];
		base = pid * VIRTUAL_PAGES;
		frame = '0;
		if (vpn >= VIRTUAL_PAGES) begin
			res.kind = dpt_pkg::OUT_RANGE;
		end else if (page_valid[base + vpn]) begin
			frame = page_frame[base + vpn];
			hit_count[pid] = bump(hit_count[pid]);
			res.kind = dpt_pkg::OUT_HIT;
		end else begin
			// Size the user pool from the current register values
			phys = (total_page_cfg > MAX_PHYSICAL_PAGES) ? MAX_PHYSICAL_PAGES
				: total_page_cfg;
			free_pool_size = (phys > reserved_page_cfg) ? phys - reserved_page_cfg : 0;
			if (pool_taken < free_pool_size) begin
				frame = dpt_pkg::FRAME_W'(phys - 1 - pool_taken);
				pool_taken = pool_taken + 1'b1;
				pool_count[pid] = bump(pool_count[pid]);
				page_frame[base + vpn] = frame;
				page_valid[base + vpn] = 1'b1;
				mapped_count[pid] = mapped_count[pid] + 1'b1;
				res.kind = dpt_pkg::OUT_POOL;
			end else begin
				// Steal the lowest valid page of the same process
				fault_count[pid] = bump(fault_count[pid]);
				vp = 0;
				while (vp < VIRTUAL_PAGES && !page_valid[base + vp])
					vp++;
				if (vp < VIRTUAL_PAGES) begin
					frame = page_frame[base + vp];
					page_valid[base + vp] = 1'b0;
					page_frame[base + vpn] = frame;
					page_valid[base + vpn] = 1'b1;
					res.kind = dpt_pkg::OUT_STEAL;
				end else begin
					res.kind = dpt_pkg::OUT_NO_VICTIM;
				end
			end
		end
		res.frame = frame;
		res.paddr = {frame, vaddr[dpt_pkg::OFFSET_W-1:0]};
		res.hits = hit_count[pid];
		res.pool_allocs = pool_count[pid];
		res.faults = fault_count[pid];
		res.mapped = mapped_count[pid];
	endtask

	task automatic compare_field(input string field,
			input logic [dpt_pkg::COUNT_W-1:0] want,
			input logic [dpt_pkg::COUNT_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	// Track register writes, predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		translation_t predicted;
		translation_t oldest;
		if (!arst_n) begin
			total_page_cfg = dpt_pkg::PHYS_PAGES_RST;
			reserved_page_cfg = dpt_pkg::SYS_PAGES_RST;
			pool_taken = '0;
			for (int i = 0; i < TABLE_DEPTH; i++)
				page_valid[i] = 1'b0;
			for (int p = 0; p < PROCESS_COUNT; p++) begin
				hit_count[p] = '0;
				pool_count[p] = '0;
				fault_count[p] = '0;
				mapped_count[p] = '0;
			end
			pending_translations.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					dpt_pkg::CFG_PHYS_PAGES: total_page_cfg = cfg_data;
					dpt_pkg::CFG_SYS_PAGES:  reserved_page_cfg = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_translations.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with nothing outstanding, frame %0h outcome %0d",
							$time, frame_number, outcome);
				end else begin
					oldest = pending_translations.pop_front();
					compare_field("frame_number", oldest.frame, frame_number);
					compare_field("physical_address", oldest.paddr, physical_address);
					compare_field("outcome", oldest.kind, outcome);
					compare_field("hits_so_far", oldest.hits, hits_so_far);
					compare_field("pool_allocs_so_far", oldest.pool_allocs,
						pool_allocs_so_far);
					compare_field("faults_so_far", oldest.faults, faults_so_far);
					compare_field("mapped_pages", oldest.mapped, mapped_pages);
				end
			end
			if (in_valid && in_ready) begin
				translate(process_id, virtual_address, predicted);
				pending_translations.push_back(predicted);
			end
		end
		outstanding = pending_translations.size();
	end

endmodule

FILE: tb/demand_paging_translator_tb.sv
`timescale 1ns / 1ps

module demand_paging_translator_tb;

	localparam int unsigned CYCLE_LIMIT = 4000000;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [dpt_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [dpt_pkg::CFG_DATA_W-1:0]   cfg_data;
	logic                             in_valid;
	logic                             in_ready;
	logic [dpt_pkg::PID_IN_W-1:0]     process_id;
	logic [dpt_pkg::VADDR_W-1:0]      virtual_address;
	logic                             out_valid;
	logic                             out_ready;
	logic [dpt_pkg::FRAME_W-1:0]      frame_number;
	logic [dpt_pkg::PADDR_W-1:0]      physical_address;
	logic [dpt_pkg::OUTCOME_W-1:0]    outcome;
	logic [dpt_pkg::COUNT_W-1:0]      hits_so_far;
	logic [dpt_pkg::COUNT_W-1:0]      pool_allocs_so_far;
	logic [dpt_pkg::COUNT_W-1:0]      faults_so_far;
	logic [dpt_pkg::MAPPED_W-1:0]     mapped_pages;
	int unsigned                      failures;
	int unsigned                      outstanding;
	int unsigned                      cycle_count = 0;
	int unsigned                      drained = 0;
	int unsigned                      random_sent = 0;

	always #6 clk = ~clk;

	demand_paging_translator DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.process_id         (process_id),
		.virtual_address    (virtual_address),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.frame_number       (frame_number),
		.physical_address   (physical_address),
		.outcome            (outcome),
		.hits_so_far        (hits_so_far),
		.pool_allocs_so_far (pool_allocs_so_far),
		.faults_so_far      (faults_so_far),
		.mapped_pages       (mapped_pages)
	);

	demand_paging_translator_checker translation_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.process_id         (process_id),
		.virtual_address    (virtual_address),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.frame_number       (frame_number),
		.physical_address   (physical_address),
		.outcome            (outcome),
		.hits_so_far        (hits_so_far),
		.pool_allocs_so_far (pool_allocs_so_far),
		.faults_so_far      (faults_so_far),
		.mapped_pages       (mapped_pages),
		.failures           (failures),
		.outstanding        (outstanding)
	);

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("demand_paging_translator verification failed");
			$finish;
		end
	end

	// Count result transfers to pace the receiver
	always @(posedge clk) begin
		if (out_valid && out_ready)
			drained <= drained + 1;
	end

	// Receiver: random stalls, one long hold-off, then a stretch always ready
	initial begin : receiver
		int unsigned hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && drained >= 150) begin
				held = 1'b1;
				hold_left = 300;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (drained >= 500 && drained < 640) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 22);
			end
		end
	end

	// Offer one item, with random idle cycles ahead of it unless steady
	task automatic send_item(input logic [dpt_pkg::PID_IN_W-1:0] pid,
			input logic [dpt_pkg::VADDR_W-1:0] addr, input bit steady);
		while (!steady && $urandom_range(99) < 22) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		process_id <= pid;
		virtual_address <= addr;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and wait until every result has been drained
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [dpt_pkg::CFG_IDX_W-1:0] idx,
			input logic [dpt_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic reconfigure_pool(input logic [dpt_pkg::CFG_DATA_W-1:0] phys,
			input logic [dpt_pkg::CFG_DATA_W-1:0] sys);
		wait_idle();
		write_reg(dpt_pkg::CFG_PHYS_PAGES, phys);
		write_reg(dpt_pkg::CFG_SYS_PAGES, sys);
	endtask

	// Mostly low pages so hits and steals recur; some wide pages and raw addresses
	task automatic run_random(input int unsigned count);
		logic [dpt_pkg::PID_IN_W-1:0] pid;
		logic [dpt_pkg::VADDR_W-1:0] addr;
		int unsigned pick;
		repeat (count) begin
			pid = dpt_pkg::PID_IN_W'($urandom_range(3));
			pick = $urandom_range(99);
			addr = $urandom();
			if (pick >= 8) begin
				addr[31:22] = '0;
				addr[21:12] = (pick < 20) ? 10'($urandom_range(1023)) : 10'($urandom_range(23));
			end
			send_item(pid, addr, random_sent >= 300 && random_sent < 420);
			random_sent++;
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = dpt_pkg::CFG_PHYS_PAGES;
		cfg_data = '0;
		in_valid = 1'b0;
		process_id = '0;
		virtual_address = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset pool: allocations, hits, table edges, out of range pages
		send_item(2'd0, 32'h0000_0000, 1'b0);
		send_item(2'd0, 32'h0000_0FFF, 1'b0);
		send_item(2'd1, 32'h003F_FFFF, 1'b0);
		send_item(2'd1, 32'h003F_F000, 1'b0);
		send_item(2'd2, 32'h0040_0000, 1'b0);
		send_item(2'd3, 32'hFFFF_FFFF, 1'b0);
		send_item(2'd2, 32'h0000_5ABC, 1'b0);
		send_item(2'd0, 32'h0000_7123, 1'b0);

		// Empty pool: fault with no victim, steals including a full table walk
		reconfigure_pool(13'd8, 13'd8);
		send_item(2'd3, 32'h0000_1000, 1'b0);
		send_item(2'd0, 32'h0000_3456, 1'b0);
		send_item(2'd0, 32'h0000_0000, 1'b0);
		send_item(2'd1, 32'h0000_2000, 1'b0);
		send_item(2'd1, 32'h0000_2FFF, 1'b0);

		// Oversized page count clamps to the maximum
		reconfigure_pool(13'd8191, 13'd0);
		send_item(2'd3, 32'h0000_A000, 1'b0);
		send_item(2'd3, 32'h0000_A800, 1'b0);

		// System count above the total, then a zero total
		reconfigure_pool(13'd1, 13'd8191);
		send_item(2'd3, 32'h0000_B000, 1'b0);
		reconfigure_pool(13'd0, 13'd0);
		send_item(2'd2, 32'h0000_6000, 1'b0);

		// Random phases over several pool settings
		reconfigure_pool(13'd64, 13'd32);
		run_random(180);
		reconfigure_pool(13'd4096, 13'd4000);
		run_random(180);
		reconfigure_pool(13'd8191, 13'd4096);
		run_random(180);
		reconfigure_pool(13'd2048, 13'd0);
		run_random(180);
		reconfigure_pool(13'd16, 13'd8191);
		run_random(180);

		wait_idle();
		repeat (40) @(negedge clk);
		if (failures == 0)
			$display("demand_paging_translator verification clean");
		else
			$display("demand_paging_translator verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/dpt_pkg.sv
design/demand_paging_translator.sv
design/dpt_checker.sv
tb/demand_paging_translator_checker.sv
tb/demand_paging_translator_tb.sv
